// File: rtl/lrac_pkg.sv
package lrac_pkg;

   localparam int RingPixelsDefault  = 8;
   localparam int CometLengthDefault = 6;

   localparam int unsigned PulseMs      = 1800;
   localparam int unsigned PulsePhaseMs = 150;

   // ceil division by 100 done as a reciprocal multiply, exact for numerators below 6500
   localparam int unsigned GaugeRecip = 10486;
   localparam int unsigned GaugeShift = 20;

   localparam logic [1:0] CmdTick    = 2'd0;
   localparam logic [1:0] CmdSetMode = 2'd1;
   localparam logic [1:0] CmdGauge   = 2'd2;
   localparam logic [1:0] CmdPulse   = 2'd3;

   localparam logic [2:0] ModeOff   = 3'd0;
   localparam logic [2:0] ModeIdle  = 3'd1;
   localparam logic [2:0] ModeWait  = 3'd2;
   localparam logic [2:0] ModeWork  = 3'd3;
   localparam logic [2:0] ModeBatt  = 3'd4;
   localparam logic [2:0] ModeGauge = 3'd5;

   localparam logic [1:0] CsrGreenMax  = 2'd0;
   localparam logic [1:0] CsrYellowMax = 2'd1;
   localparam logic [1:0] CsrChaseStep = 2'd2;
   localparam logic [1:0] CsrBlinkHalf = 2'd3;

   localparam logic [6:0]  GreenMaxReset  = 7'd50;
   localparam logic [6:0]  YellowMaxReset = 7'd80;
   localparam logic [15:0] ChaseStepReset = 16'd80;
   localparam logic [14:0] BlinkHalfReset = 15'd500;

   localparam logic KindBar   = 1'b0;
   localparam logic KindComet = 1'b1;

   localparam logic [7:0] LevelFull   = 8'd255;
   localparam logic [7:0] LevelOrange = 8'd90;
   localparam logic [7:0] LevelGrey   = 8'd2;
   localparam logic [7:0] LevelOff    = 8'd0;

   localparam int QueueDepth    = 2;
   localparam int QueuePtrWidth = 1;

   // one frame as the back end needs it: a lit bar over a background, or a comet
   typedef struct packed {
      logic       kind;
      logic [6:0] lit;
      logic [7:0] fg_red;
      logic [7:0] fg_green;
      logic [7:0] fg_blue;
      logic       bg_grey;
      logic [5:0] comet_pos;
   } frame_desc_type;

   function automatic frame_desc_type bar_desc(input logic [6:0] lit, input logic [7:0] r,
                                               input logic [7:0] g, input logic [7:0] b,
                                               input logic grey);
      frame_desc_type d;
      d.kind      = KindBar;
      d.lit       = lit;
      d.fg_red    = r;
      d.fg_green  = g;
      d.fg_blue   = b;
      d.bg_grey   = grey;
      d.comet_pos = 6'd0;
      return d;
   endfunction

endpackage

// File: rtl/lrac_front.sv
module lrac_front import lrac_pkg::*; #(
   parameter int RING_PIXELS = RingPixelsDefault
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [1:0]     req_command,
   input  logic [2:0]     req_mode,
   input  logic [7:0]     req_percent,
   input  logic           csr_write,
   input  logic [1:0]     csr_index,
   input  logic [15:0]    csr_data,
   output logic           desc_push,
   output frame_desc_type desc_out
);

   localparam logic [6:0] FullLit = 7'(RING_PIXELS);
   localparam logic [5:0] LastPos = 6'(RING_PIXELS - 1);

   logic [6:0]  green_max_ff, green_max_in;
   logic [6:0]  yellow_max_ff, yellow_max_in;
   logic [15:0] chase_step_ff, chase_step_in;
   logic [14:0] blink_half_ff, blink_half_in;

   logic [31:0] time_ff, time_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [31:0] pulse_end_ff, pulse_end_in;
   logic [31:0] since_ff, since_in;
   logic [7:0]  phase_cnt_ff, phase_cnt_in;
   logic        phase_odd_ff, phase_odd_in;
   logic [2:0]  mode_ff, mode_in;
   logic [5:0]  comet_pos_ff, comet_pos_in;
   logic        blink_on_ff, blink_on_in;
   logic [6:0]  gauge_level_ff, gauge_level_in;

   logic [31:0] now;
   logic        pulsing;
   logic [31:0] el_tick;
   logic [31:0] since_next;
   logic [5:0]  pos_next;
   logic [6:0]  pct_sat;
   logic [13:0] gauge_num;
   logic [27:0] gauge_prod;
   logic [6:0]  lit_raw;
   logic [6:0]  lit;
   logic [7:0]  gauge_red, gauge_green;
   logic [31:0] blink_lim;

   assign now        = (req_command == CmdTick) ? time_ff + 32'd1 : time_ff;
   assign pulsing    = now < pulse_end_ff;
   assign el_tick    = elapsed_ff + 32'd1;
   assign since_next = since_ff + 32'd1;
   assign pos_next   = (comet_pos_ff == LastPos) ? 6'd0 : comet_pos_ff + 6'd1;
   assign pct_sat    = (req_percent > 8'd100) ? 7'd100 : req_percent[6:0];
   assign gauge_num  = 14'(pct_sat) * 14'(RING_PIXELS) + 14'd99;
   assign gauge_prod = 28'(gauge_num) * 28'(GaugeRecip);
   assign lit_raw    = gauge_prod[GaugeShift +: 7];
   assign blink_lim  = (mode_ff == ModeWait) ? {17'd0, blink_half_ff}
                                             : {16'd0, blink_half_ff, 1'b0};

   always_comb begin
      if (lit_raw == 7'd0) begin
         lit = 7'd1;
      end else if (lit_raw > FullLit) begin
         lit = FullLit;
      end else begin
         lit = lit_raw;
      end
      // green test first, so thresholds out of order still resolve
      if (pct_sat <= green_max_ff) begin
         gauge_red   = LevelOff;
         gauge_green = LevelFull;
      end else if (pct_sat <= yellow_max_ff) begin
         gauge_red   = LevelFull;
         gauge_green = LevelFull;
      end else begin
         gauge_red   = LevelFull;
         gauge_green = LevelOff;
      end
   end

   always_comb begin
      green_max_in  = green_max_ff;
      yellow_max_in = yellow_max_ff;
      chase_step_in = chase_step_ff;
      blink_half_in = blink_half_ff;
      if (csr_write) begin
         unique case (csr_index)
            CsrGreenMax:  green_max_in  = csr_data[6:0];
            CsrYellowMax: yellow_max_in = csr_data[6:0];
            CsrChaseStep: chase_step_in = csr_data;
            CsrBlinkHalf: blink_half_in = csr_data[14:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      time_in        = time_ff;
      elapsed_in     = elapsed_ff;
      pulse_end_in   = pulse_end_ff;
      since_in       = since_ff;
      phase_cnt_in   = phase_cnt_ff;
      phase_odd_in   = phase_odd_ff;
      mode_in        = mode_ff;
      comet_pos_in   = comet_pos_ff;
      blink_on_in    = blink_on_ff;
      gauge_level_in = gauge_level_ff;
      desc_push      = 1'b0;
      desc_out       = bar_desc(7'd0, LevelOff, LevelOff, LevelOff, 1'b0);

      if (accept) begin
         unique case (req_command)
            CmdPulse: begin
               pulse_end_in = time_ff + 32'(PulseMs);
               mode_in      = ModeOff;
               since_in     = 32'd0;
               phase_cnt_in = 8'd0;
               phase_odd_in = 1'b0;
            end
            CmdTick: begin
               time_in    = now;
               elapsed_in = el_tick;
               since_in   = since_next;
               // phase parity of the time since the pulse started, in 150 ms slots
               if (since_next == 32'd0) begin
                  phase_cnt_in = 8'd0;
                  phase_odd_in = 1'b0;
               end else if (phase_cnt_ff == 8'(PulsePhaseMs - 1)) begin
                  phase_cnt_in = 8'd0;
                  phase_odd_in = ~phase_odd_ff;
               end else begin
                  phase_cnt_in = phase_cnt_ff + 8'd1;
               end
               if (pulsing) begin
                  desc_push = 1'b1;
                  desc_out  = bar_desc(FullLit, LevelOff,
                                       phase_odd_in ? LevelOff : LevelFull, LevelOff, 1'b0);
               end else if (mode_ff == ModeWork) begin
                  if (el_tick >= {16'd0, chase_step_ff}) begin
                     elapsed_in         = 32'd0;
                     comet_pos_in       = pos_next;
                     desc_push          = 1'b1;
                     desc_out.kind      = KindComet;
                     desc_out.comet_pos = pos_next;
                  end
               end else if (mode_ff == ModeWait || mode_ff == ModeBatt) begin
                  if (el_tick >= blink_lim) begin
                     elapsed_in  = 32'd0;
                     blink_on_in = ~blink_on_ff;
                     desc_push   = 1'b1;
                     if (!blink_on_in) begin
                        desc_out = bar_desc(7'd0, LevelOff, LevelOff, LevelOff, 1'b0);
                     end else if (mode_ff == ModeWait) begin
                        desc_out = bar_desc(FullLit, LevelFull, LevelOff, LevelOff, 1'b0);
                     end else begin
                        desc_out = bar_desc(FullLit, LevelFull, LevelOrange, LevelOff, 1'b0);
                     end
                  end
               end
            end
            CmdSetMode: begin
               if (!pulsing && req_mode != mode_ff) begin
                  mode_in      = req_mode;
                  elapsed_in   = 32'd0;
                  comet_pos_in = 6'd0;
                  blink_on_in  = 1'b1;
                  desc_push    = 1'b1;
                  unique case (req_mode)
                     ModeIdle: desc_out = bar_desc(FullLit, LevelOff, LevelFull, LevelOff, 1'b0);
                     ModeWait: desc_out = bar_desc(FullLit, LevelFull, LevelOff, LevelOff, 1'b0);
                     ModeBatt: desc_out = bar_desc(FullLit, LevelFull, LevelOrange, LevelOff,
                                                   1'b0);
                     ModeWork: desc_out = bar_desc(7'd1, LevelFull, LevelFull, LevelOff, 1'b0);
                     default:  desc_out = bar_desc(7'd0, LevelOff, LevelOff, LevelOff, 1'b0);
                  endcase
               end
            end
            CmdGauge: begin
               if (!pulsing && !(mode_ff == ModeGauge && pct_sat == gauge_level_ff)) begin
                  mode_in        = ModeGauge;
                  gauge_level_in = pct_sat;
                  desc_push      = 1'b1;
                  desc_out       = bar_desc(lit, gauge_red, gauge_green, LevelOff, 1'b1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         green_max_ff   <= GreenMaxReset;
         yellow_max_ff  <= YellowMaxReset;
         chase_step_ff  <= ChaseStepReset;
         blink_half_ff  <= BlinkHalfReset;
         time_ff        <= 32'd0;
         elapsed_ff     <= 32'd0;
         pulse_end_ff   <= 32'd0;
         since_ff       <= 32'd0;
         phase_cnt_ff   <= 8'd0;
         phase_odd_ff   <= 1'b0;
         mode_ff        <= ModeOff;
         comet_pos_ff   <= 6'd0;
         blink_on_ff    <= 1'b0;
         gauge_level_ff <= 7'd0;
      end else begin
         green_max_ff   <= green_max_in;
         yellow_max_ff  <= yellow_max_in;
         chase_step_ff  <= chase_step_in;
         blink_half_ff  <= blink_half_in;
         time_ff        <= time_in;
         elapsed_ff     <= elapsed_in;
         pulse_end_ff   <= pulse_end_in;
         since_ff       <= since_in;
         phase_cnt_ff   <= phase_cnt_in;
         phase_odd_ff   <= phase_odd_in;
         mode_ff        <= mode_in;
         comet_pos_ff   <= comet_pos_in;
         blink_on_ff    <= blink_on_in;
         gauge_level_ff <= gauge_level_in;
      end
   end

endmodule

// File: rtl/lrac_queue.sv
module lrac_queue import lrac_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  frame_desc_type push_desc,
   input  logic           pop,
   output logic           full,
   output logic           valid,
   output frame_desc_type head
);

   frame_desc_type                entries_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrWidth:0]        count_ff, count_in;
   logic                          do_pop;

   assign full   = count_ff == (QueuePtrWidth + 1)'(QueueDepth);
   assign valid  = count_ff != '0;
   assign head   = entries_ff[rd_ptr_ff];
   assign do_pop = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// File: rtl/lrac_back.sv
module lrac_back import lrac_pkg::*; #(
   parameter int RING_PIXELS  = RingPixelsDefault,
   parameter int COMET_LENGTH = CometLengthDefault
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           desc_valid,
   input  frame_desc_type desc,
   output logic           desc_pop,
   output logic           rsp_empty,
   input  logic           rsp_pop,
   output logic [5:0]     rsp_pixel_index,
   output logic [7:0]     rsp_red,
   output logic [7:0]     rsp_green,
   output logic [7:0]     rsp_blue,
   output logic           rsp_last_pixel
);

   localparam int CometDiv = (COMET_LENGTH > 1) ? COMET_LENGTH - 1 : 1;
   localparam logic [5:0] LastPix = 6'(RING_PIXELS - 1);

   function automatic logic [63:0][7:0] comet_lut();
      logic [63:0][7:0] lut;
      int               d;
      for (int i = 0; i < 64; i++) begin
         d      = (i * 125) / CometDiv;
         lut[i] = (d > 255) ? 8'd0 : 8'(255 - d);
      end
      return lut;
   endfunction

   localparam logic [63:0][7:0] CometLut = comet_lut();

   logic       out_valid_ff, out_valid_in;
   logic [5:0] pix_ff, pix_in;
   logic [5:0] index_ff;
   logic [7:0] red_ff, green_ff, blue_ff;
   logic       last_ff;

   logic       advance;
   logic       is_last;
   logic [6:0] behind_wide;
   logic [5:0] behind;
   logic [7:0] pix_red, pix_green, pix_blue;

   assign advance   = !out_valid_ff || rsp_pop;
   assign is_last   = pix_ff == LastPix;
   assign desc_pop  = advance && desc_valid && is_last;
   // distance behind the comet head, around the ring
   assign behind_wide = (desc.comet_pos >= pix_ff)
                      ? {1'b0, desc.comet_pos - pix_ff}
                      : {1'b0, desc.comet_pos} + 7'(RING_PIXELS) - {1'b0, pix_ff};
   assign behind      = behind_wide[5:0];

   always_comb begin
      pix_red   = LevelOff;
      pix_green = LevelOff;
      pix_blue  = LevelOff;
      if (desc.kind == KindComet) begin
         if ({1'b0, behind} < 7'(COMET_LENGTH)) begin
            pix_red   = CometLut[behind];
            pix_green = CometLut[behind];
         end
      end else if ({1'b0, pix_ff} < desc.lit) begin
         pix_red   = desc.fg_red;
         pix_green = desc.fg_green;
         pix_blue  = desc.fg_blue;
      end else if (desc.bg_grey) begin
         pix_red   = LevelGrey;
         pix_green = LevelGrey;
         pix_blue  = LevelGrey;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      pix_in       = pix_ff;
      if (advance) begin
         out_valid_in = desc_valid;
         if (desc_valid) begin
            pix_in = is_last ? 6'd0 : pix_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pix_ff       <= 6'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         pix_ff       <= pix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && desc_valid) begin
         index_ff <= pix_ff;
         red_ff   <= pix_red;
         green_ff <= pix_green;
         blue_ff  <= pix_blue;
         last_ff  <= is_last;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_pixel_index = index_ff;
   assign rsp_red         = red_ff;
   assign rsp_green       = green_ff;
   assign rsp_blue        = blue_ff;
   assign rsp_last_pixel  = last_ff;

endmodule

// File: rtl/led_ring_animation_controller.sv
// channel   ports                                   word
// req       req_push / req_full                     command, mode, percent
// rsp       rsp_empty / rsp_pop                     pixel index, rgb, last flag
// csr       csr_valid / csr_ready                   register index, write data
//
// a command is classified in the cycle it is taken; a frame then leaves at one pixel
// per cycle while rsp_pop keeps up; a frame that a command draws is RING_PIXELS pixels
// a two-entry frame queue sits between the two, so commands keep being taken while
// the output stalls, until two frames are waiting
// synchronous reset; no clearing pass, the block is ready in the cycle after reset
module led_ring_animation_controller import lrac_pkg::*; #(
   parameter int RING_PIXELS  = RingPixelsDefault,
   parameter int COMET_LENGTH = CometLengthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_command,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_percent,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [5:0]  rsp_pixel_index,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last_pixel,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic           accept;
   logic           desc_push;
   frame_desc_type push_desc;
   logic           q_valid;
   logic           q_pop;
   frame_desc_type q_head;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   lrac_front #(
      .RING_PIXELS(RING_PIXELS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_command (req_command),
      .req_mode    (req_mode),
      .req_percent (req_percent),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .desc_push   (desc_push),
      .desc_out    (push_desc)
   );

   lrac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .full      (req_full),
      .valid     (q_valid),
      .head      (q_head)
   );

   lrac_back #(
      .RING_PIXELS (RING_PIXELS),
      .COMET_LENGTH(COMET_LENGTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .desc_valid      (q_valid),
      .desc            (q_head),
      .desc_pop        (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule

// File: rtl/lrac_checker.sv
module lrac_checker import lrac_pkg::*; #(
   parameter int RING_PIXELS = RingPixelsDefault
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [5:0] rsp_pixel_index,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic       rsp_last_pixel
);

   localparam logic [5:0] LastPix = 6'(RING_PIXELS - 1);

   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown straight after reset");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_last_pixel == (rsp_pixel_index == LastPix)))
      else $error("last flag not on the final pixel");

   a_pixel_order: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last_pixel)
      |=> (rsp_empty || rsp_pixel_index == $past(rsp_pixel_index) + 6'd1))
      else $error("pixel skipped within a frame");

   a_blue_grey: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_blue != 8'd0)
      |-> (rsp_blue == LevelGrey && rsp_red == LevelGrey && rsp_green == LevelGrey))
      else $error("blue seen outside the grey background");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_pixel_index)))
      else $error("stalled word dropped");

endmodule

bind led_ring_animation_controller lrac_checker #(
   .RING_PIXELS(RING_PIXELS)
) u_lrac_checker (.*);
